### design/sapt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapt_pkg
// Shared types and constants for the start-of-frame audio PLL tracker.
// ----------------------------------------------------------------------------
package sapt_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam int NOMINAL_W  = 31;
  localparam int STEP_W     = 16;
  localparam int FRACTION_W = 32;
  localparam int WINDOW_W   = 8;
  localparam int AVG_W      = 32;
  localparam int AVG_REM_W  = 4;

  localparam logic [NOMINAL_W-1:0]  NOMINAL_RESET  = 31'd2457600;
  localparam logic [STEP_W-1:0]     STEP_RESET     = 16'd1;
  localparam logic [FRACTION_W-1:0] FRACTION_RESET = 32'd0;
  localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 8'd100;

  // Averaging weight is 1/2^AVG_SHIFT, tolerance is nominal >> TOL_SHIFT
  localparam int AVG_SHIFT = 3;
  localparam int TOL_SHIFT = 7;

  localparam int PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_NOMINAL  = 2'd0,
    REG_STEP     = 2'd1,
    REG_FRACTION = 2'd2,
    REG_WINDOW   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_AVG,
    ST_ERR,
    ST_DIV,
    ST_APPLY,
    ST_DONE
  } state_t;

endpackage

### design/sof_audio_pll_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_audio_pll_tracker
// Start-of-frame driven audio PLL fractional numerator trim.
// ----------------------------------------------------------------------------
// Sequence: an event that closes no window goes straight to the result; a
// closing one is checked and rejected, or averaged and checked against nominal,
// and a correction runs the 32-step restoring divider before it is applied.
// Items are handled one at a time: s_tready is high only in idle.
// Reset (rst, synchronous): registers take their defaults, average follows
// nominal, numerator follows the initial fraction, no result pending.
module sof_audio_pll_tracker
  import sapt_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // frame event items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [31:0] capture_value
  input  logic                  s_tuser,   // [0] link_attached
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [31:0] pll_fraction
  output logic [1:0]            m_tuser,   // [0] measured, [1] pll_write
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int DIV_STEPS = FRACTION_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // configuration registers
  logic [NOMINAL_W-1:0]  nominal_count;
  logic [STEP_W-1:0]     step_size;
  logic [FRACTION_W-1:0] initial_fraction;
  logic [WINDOW_W-1:0]   window_events;

  // tracking state
  logic [WINDOW_W-1:0]    window_counter;
  logic [COUNT_WIDTH-1:0] last_capture;
  logic [AVG_W-1:0]       average_count;
  logic [AVG_REM_W-1:0]   average_remainder;
  logic [FRACTION_W-1:0]  fraction_now;

  // per-item working registers
  state_t                 state, state_next;
  logic [COUNT_WIDTH-1:0] period_q;
  logic                   attached_q;
  logic                   measured_q;
  logic                   write_q;
  logic                   err_neg;
  logic [FRACTION_W-1:0]  div_quo;
  logic [STEP_W-1:0]      div_rem;
  logic [DIV_CNT_W-1:0]   div_count;

  logic       in_accept;
  logic       cfg_write;
  cfg_reg_t   cfg_index;
  logic       out_free;

  assign in_accept = s_tvalid && s_tready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = cfg_reg_t'(paddr[PADDR_W-1:2]);
  assign out_free  = !m_tvalid || m_tready;
  assign pready    = 1'b1;

  always_comb begin
    case (cfg_index)
      REG_NOMINAL:  prdata = 32'(nominal_count);
      REG_STEP:     prdata = 32'(step_size);
      REG_FRACTION: prdata = initial_fraction;
      REG_WINDOW:   prdata = 32'(window_events);
      default:      prdata = '0;
    endcase
  end

  // ---- window period check ----
  logic [31:0]        period_ext;
  logic signed [33:0] dev_s;
  logic [33:0]        dev_abs;
  logic               in_band;

  assign period_ext = 32'(period_q);
  assign dev_s      = $signed({2'b00, period_ext}) - $signed({3'b000, nominal_count});
  assign dev_abs    = dev_s[33] ? 34'(-dev_s) : 34'(dev_s);
  assign in_band    = attached_q && (dev_abs < 34'(nominal_count >> TOL_SHIFT));

  // ---- eighth-weight average with carried remainder ----
  logic signed [33:0]          diff_s;
  logic signed [33:0]          diff_q;
  logic signed [33:0]          diff_r;
  logic signed [AVG_REM_W-1:0] r4;
  logic signed [AVG_REM_W:0]   rem_sum;
  logic signed [1:0]           rem_q;
  logic signed [AVG_REM_W:0]   rem_left;
  logic [AVG_W-1:0]            avg_new;

  assign diff_s = $signed({2'b00, period_ext}) - $signed({2'b00, average_count});
  // truncate toward zero
  assign diff_q = diff_s[33] ? ((diff_s + 34'sd7) >>> AVG_SHIFT) : (diff_s >>> AVG_SHIFT);
  assign diff_r = diff_s - (diff_q <<< AVG_SHIFT);
  assign r4     = diff_r[AVG_REM_W-1:0];
  assign rem_sum = {average_remainder[AVG_REM_W-1], average_remainder} + {r4[AVG_REM_W-1], r4};

  always_comb begin
    if (rem_sum >= 5'sd8) begin
      rem_q = 2'sd1;
    end else if (rem_sum <= -5'sd8) begin
      rem_q = -2'sd1;
    end else begin
      rem_q = 2'sd0;
    end
  end

  assign rem_left = rem_sum - {rem_q, 3'b000};
  assign avg_new  = average_count + diff_q[AVG_W-1:0] + {{(AVG_W-2){rem_q[1]}}, rem_q};

  // ---- error against nominal ----
  logic signed [33:0]    err_s;
  logic [FRACTION_W-1:0] err_abs;
  logic [STEP_W-1:0]     step_eff;
  logic                  needs_trim;

  assign err_s      = $signed({2'b00, average_count}) - $signed({3'b000, nominal_count});
  assign err_abs    = err_s[33] ? FRACTION_W'(-err_s) : FRACTION_W'(err_s);
  assign step_eff   = (step_size == '0) ? STEP_W'(1) : step_size;
  assign needs_trim = err_abs > FRACTION_W'(step_eff);

  // ---- restoring divider step ----
  logic [STEP_W:0] div_shift;
  logic            div_ge;

  assign div_shift = {div_rem, div_quo[FRACTION_W-1]};
  assign div_ge    = div_shift >= {1'b0, step_eff};

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (window_counter == window_events) ? ST_CHECK : ST_DONE;
        end
      end
      ST_CHECK: state_next = in_band ? ST_AVG : ST_DONE;
      ST_AVG:   state_next = ST_ERR;
      ST_ERR:   state_next = needs_trim ? ST_DIV : ST_DONE;
      ST_DIV: begin
        if (div_count == DIV_LAST) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: s_tready = 1'b1;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- configuration and tracking state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_count     <= NOMINAL_RESET;
      step_size         <= STEP_RESET;
      initial_fraction  <= FRACTION_RESET;
      window_events     <= WINDOW_RESET;
      window_counter    <= '0;
      last_capture      <= '0;
      average_count     <= AVG_W'(NOMINAL_RESET);
      average_remainder <= '0;
      fraction_now      <= FRACTION_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NOMINAL: begin
            nominal_count     <= pwdata[NOMINAL_W-1:0];
            average_count     <= AVG_W'(pwdata[NOMINAL_W-1:0]);
            average_remainder <= '0;
          end
          REG_STEP:     step_size <= pwdata[STEP_W-1:0];
          REG_FRACTION: begin
            initial_fraction <= pwdata;
            fraction_now     <= pwdata;
          end
          REG_WINDOW:   window_events <= pwdata[WINDOW_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        if (window_counter != window_events) begin
          window_counter <= window_counter + WINDOW_W'(1);
        end else begin
          window_counter <= WINDOW_W'(1);
          last_capture   <= s_tdata[COUNT_WIDTH-1:0];
        end
      end
      if (state == ST_AVG) begin
        average_count     <= avg_new;
        average_remainder <= rem_left[AVG_REM_W-1:0];
      end
      if (state == ST_APPLY) begin
        // move against the sign of the error
        fraction_now <= err_neg ? fraction_now + div_quo : fraction_now - div_quo;
      end
    end
  end

  // ---- per-item working registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      measured_q <= 1'b0;
      write_q    <= 1'b0;
      div_count  <= '0;
    end else begin
      if (in_accept) begin
        measured_q <= (window_counter == window_events);
        write_q    <= 1'b0;
      end
      if (state == ST_ERR) begin
        div_count <= '0;
      end else if (state == ST_DIV) begin
        div_count <= div_count + DIV_CNT_W'(1);
      end
      if (state == ST_APPLY) begin
        write_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      period_q   <= s_tdata[COUNT_WIDTH-1:0] - last_capture;
      attached_q <= s_tuser;
    end
    if (state == ST_ERR) begin
      err_neg <= err_s[33];
      div_quo <= err_abs;
      div_rem <= '0;
    end else if (state == ST_DIV) begin
      div_quo <= {div_quo[FRACTION_W-2:0], div_ge};
      div_rem <= div_ge ? STEP_W'(div_shift - {1'b0, step_eff}) : div_shift[STEP_W-1:0];
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= fraction_now;
      m_tuser <= {write_q, measured_q};
    end
  end

endmodule

### verif/sof_audio_pll_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_audio_pll_tracker_tb
// Drives start-of-frame items into the tracker and checks every result item
// against an in-bench trim predictor. A directed opening covers the tolerance
// boundaries, a detached link, numerator wrap and capture wrap. Randomised
// phases follow: well-formed capture sequences with noise mixed in, register
// extremes, random idling on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module sof_audio_pll_tracker_tb
  import sapt_pkg::*;
();

  typedef struct packed {
    logic        measured;
    logic        pll_write;
    logic [31:0] fraction;
  } trim_result_t;

  class pll_trim_scoreboard;
    bit [30:0]    nominal_q;
    bit [15:0]    step_q;
    bit [31:0]    init_frac_q;
    bit [7:0]     window_q;
    bit [7:0]     event_count;
    bit [31:0]    last_capture;
    bit [31:0]    avg_count;
    int           avg_rem;
    bit [31:0]    fraction;
    trim_result_t expected_trims[$];
    int           fails;

    function new();
      nominal_q    = NOMINAL_RESET;
      step_q       = STEP_RESET;
      init_frac_q  = FRACTION_RESET;
      window_q     = WINDOW_RESET;
      event_count  = '0;
      last_capture = '0;
      avg_count    = {1'b0, NOMINAL_RESET};
      avg_rem      = 0;
      fraction     = FRACTION_RESET;
      fails        = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [31:0] v);
      case (r)
        REG_NOMINAL: begin
          nominal_q = v[30:0];
          avg_count = {1'b0, v[30:0]};
          avg_rem   = 0;
        end
        REG_STEP: begin
          step_q = v[15:0];
        end
        REG_FRACTION: begin
          init_frac_q = v;
          fraction    = v;
        end
        REG_WINDOW: begin
          window_q = v[7:0];
        end
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_trims.size();
    endfunction

    // Work out the result for one accepted frame event and queue it
    function void predict_trim(logic [31:0] cap, logic att);
      trim_result_t r;
      bit [31:0]    period;
      bit [31:0]    delta;
      longint       nom, tol, dev, diff, rem, avg, err, abs_err, stp;
      r.measured  = 1'b0;
      r.pll_write = 1'b0;
      if (event_count != window_q) begin
        event_count = event_count + 8'd1;
      end else begin
        period       = cap - last_capture;
        nom          = longint'(nominal_q);
        tol          = nom >>> TOL_SHIFT;
        event_count  = 8'd1;
        last_capture = cap;
        r.measured   = 1'b1;
        dev = longint'(period) - nom;
        if (dev < 0) dev = -dev;
        if (att && dev < tol) begin
          diff      = longint'(period) - longint'(avg_count);
          rem       = longint'(avg_rem) + diff % 8;
          avg       = longint'(avg_count) + diff / 8 + rem / 8;
          avg_rem   = int'(rem % 8);
          avg_count = avg[31:0];
          err       = longint'(avg_count) - nom;
          abs_err   = (err < 0) ? -err : err;
          stp       = (step_q == 0) ? 1 : longint'(step_q);
          if (abs_err > stp) begin
            delta = 32'(abs_err / stp);
            if (err > 0) fraction = fraction - delta;
            else fraction = fraction + delta;
            r.pll_write = 1'b1;
          end
        end
      end
      r.fraction = fraction;
      expected_trims.push_back(r);
    endfunction

    function void check_result(logic measured, logic pll_write, logic [31:0] frac);
      trim_result_t e;
      if (expected_trims.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result with nothing expected: measured=%0b write=%0b fraction=%h",
                   $time, measured, pll_write, frac);
        return;
      end
      e = expected_trims.pop_front();
      if (e.measured !== measured || e.pll_write !== pll_write || e.fraction !== frac) begin
        fails++;
        if (fails <= 10)
          $display("%0t: mismatch: measured %0b/%0b write %0b/%0b fraction %h/%h (exp/act)",
                   $time, e.measured, measured, e.pll_write, pll_write, e.fraction, frac);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [31:0]        s_tdata;   // [31:0] capture_value
  logic               s_tuser;   // [0] link_attached
  logic               m_tvalid;
  logic               m_tready;
  logic [31:0]        m_tdata;   // [31:0] pll_fraction
  logic [1:0]         m_tuser;   // [0] measured, [1] pll_write
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  pll_trim_scoreboard sb;
  int                 send_idle_pct;
  int                 rcv_idle_pct;
  bit                 hold_request;

  sof_audio_pll_tracker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("sof_audio_pll_tracker verification failed");
    $finish;
  end

  // Result side: check accepted items, then pick tready for the next edge
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tuser[0], m_tuser[1], m_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (int'($urandom_range(99)) >= rcv_idle_pct);
      end
    end
  end

  task automatic cfg_write(cfg_reg_t r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(r, v);
    // idle before returning so the next transfer starts on a fresh edge
    @(posedge clk);
  endtask

  task automatic send_event(logic [31:0] cap, logic att);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cap;
    s_tuser  <= att;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.predict_trim(cap, att);
  endtask

  // Capture one nominal period (plus offset) after the last measured one
  task automatic send_offset(int off, logic att);
    send_event(sb.last_capture + {1'b0, sb.nominal_q} + 32'(off), att);
  endtask

  task automatic send_random_item();
    int          tol;
    int          off;
    int unsigned pick;
    tol  = int'(sb.nominal_q >> TOL_SHIFT);
    pick = $urandom_range(99);
    if (sb.event_count != sb.window_q || pick >= 90) begin
      send_event($urandom, 1'($urandom_range(1)));
    end else if (pick < 70 || pick >= 80) begin
      off = (tol == 0) ? 0 : int'($urandom_range(2 * (tol - 1))) - (tol - 1);
      send_offset(off, pick < 70);
    end else begin
      // sit exactly on the tolerance edge
      send_offset($urandom_range(1) ? tol : -tol, 1'b1);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic run_phase(bit [30:0] nom, bit [15:0] stp, bit [31:0] frac, bit [7:0] win,
                           int n_items, bit hold);
    cfg_write(REG_NOMINAL, {1'b0, nom});
    cfg_write(REG_STEP, {16'b0, stp});
    cfg_write(REG_FRACTION, frac);
    cfg_write(REG_WINDOW, {24'b0, win});
    if (hold) hold_request = 1'b1;
    repeat (n_items) send_random_item();
    wait_drained();
  endtask

  initial begin
    int dir_offsets[12] = '{780, 781, -781, -780, 0, 50, -60000, -700, -700, -700, -700, 3000};
    bit dir_attach[12]  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                            1'b1};
    sb            = new();
    send_idle_pct = 37;
    rcv_idle_pct  = 61;
    hold_request  = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, capture extremes
    send_event(32'h0000_0000, 1'b0);
    send_event(32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // counter already at the window: next item measures; numerator wraps below zero
    cfg_write(REG_NOMINAL, 32'd100000);
    cfg_write(REG_STEP, 32'd1);
    cfg_write(REG_FRACTION, 32'd5);
    cfg_write(REG_WINDOW, 32'd2);
    send_offset(100, 1'b1);
    wait_drained();
    cfg_write(REG_WINDOW, 32'd1);
    foreach (dir_offsets[i]) send_offset(dir_offsets[i], dir_attach[i]);
    send_event(32'hFFFF_FFFF, 1'b1);
    send_offset(10, 1'b1);   // period spans the capture wrap
    send_event(32'h0000_0000, 1'b1);
    wait_drained();

    run_phase(31'd1000000, 16'd1, 32'h0000_0010, 8'd1, 220, 1'b0);
    run_phase(31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFF0, 8'd2, 200, 1'b0);

    send_idle_pct = 61;
    rcv_idle_pct  = 37;
    // tiny nominal rejects everything, zero step
    run_phase(31'd1, 16'd0, 32'h0, 8'd1, 40, 1'b0);
    run_phase(31'd3000, 16'd2, $urandom, 8'd3, 200, 1'b0);

    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    run_phase(31'($urandom_range(32'h7FFF_FFFF, 256)), 16'($urandom_range(16, 1)), $urandom,
              8'($urandom_range(8, 1)), 200, 1'b1);
    run_phase(NOMINAL_RESET, 16'd1, $urandom, 8'd255, 270, 1'b0);
    // window of zero: counter runs on and wraps before each measurement
    run_phase(NOMINAL_RESET, 16'd1, $urandom, 8'd0, 280, 1'b0);

    repeat (50) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("sof_audio_pll_tracker verification clean");
    end else begin
      $display("sof_audio_pll_tracker verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/sapt_pkg.sv
design/sof_audio_pll_tracker.sv
verif/sof_audio_pll_tracker_tb.sv
